// ===== hdl/radix_digit_converter_assert.svh =====
// Assertion macros for the radix digit converter checker.
// Used by rdc_checker; needs nothing else.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Check a property on every rising edge while reset is released.
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rdc_pkg.sv =====
// Shared constants, job type and digit encoding for the radix digit converter.
// No dependencies; used by every module of the block except rdc_ram.
`default_nettype none

package rdc_pkg;

    // Sizing
    localparam int DIGIT_DEPTH = 32;
    localparam int VALUE_BITS  = 31;
    localparam int BASE_BITS   = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 8;

    // Legal radix range
    localparam int BASE_MIN = 2;
    localparam int BASE_MAX = 36;

    // Character encoding
    localparam int                   DEC_RADIX = 10;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A    = 8'h41;

    // Divider: quotient bits retired per cycle and cycles per division
    localparam int REM_BITS   = BASE_BITS + 1;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_BITS   = DIV_CYCLES * DIV_STEPS;
    localparam int CNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Digit stack addressing
    localparam int ADDR_BITS = $clog2(DIGIT_DEPTH);
    localparam int SP_BITS   = $clog2(DIGIT_DEPTH + 1);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // How the back end must treat a job
    typedef enum logic [1:0] {
        K_CONV,
        K_ZERO,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [BASE_BITS-1:0]  base;
        t_kind                 kind;
    } t_job;

    // Map a digit value 0..35 to '0'..'9', 'A'..'Z'
    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = CHAR_BITS'(d);
        if (d < DIGIT_BITS'(DEC_RADIX)) begin
            return CHAR_ZERO + ext;
        end
        return CHAR_A + ext - CHAR_BITS'(DEC_RADIX);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/radix_digit_converter.sv =====
// Radix digit converter: turns a non-negative integer into ASCII digits in a
// radix of 2 to 36, most significant digit first, last_digit on the final
// word. A zero value gives the single word '0'; a radix outside 2..36 gives
// one word with bad_base set and digit_char zero. Input words go into a
// two-entry job queue, so up to two can be taken while the back end is busy.
// The divider retires eight quotient bits per cycle, and the digit stack RAM gives
// one digit per cycle on readback while the output is not stalled. Zero and bad
// radix words skip the divider and go straight to the output register.
// Depends on rdc_pkg, rdc_front, rdc_back.
`default_nettype none

module radix_digit_converter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic [rdc_pkg::BASE_BITS-1:0]  i_base,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [rdc_pkg::CHAR_BITS-1:0]       o_digit_char,
    output logic                                o_last_digit,
    output logic                                o_bad_base
);

    import rdc_pkg::*;

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    // Accept and classify
    rdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_base      (i_base),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // Convert and emit
    rdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job),
        .o_job_pop    (w_job_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .o_bad_base   (o_bad_base)
    );

endmodule

`default_nettype wire

// ===== hdl/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the digit stack.
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/rdc_front.sv =====
// Front end: accepts input words, classifies them and queues them as jobs.
// Depends on rdc_pkg.
`default_nettype none

module rdc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic [rdc_pkg::BASE_BITS-1:0]  i_base,
    output logic                              o_job_valid,
    output rdc_pkg::t_job                     o_job,
    input  wire logic                         i_job_pop
);

    import rdc_pkg::*;

    t_job                 r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;
    t_job                 w_job;
    logic                 w_push;
    logic                 w_pop;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Classify: bad radix first, then zero value, else a real conversion
    always_comb begin
        w_job.value = i_value;
        w_job.base  = i_base;
        if (i_base < BASE_BITS'(BASE_MIN) || i_base > BASE_BITS'(BASE_MAX)) begin
            w_job.kind = K_BAD;
        end else if (i_value == '0) begin
            w_job.kind = K_ZERO;
        end else begin
            w_job.kind = K_CONV;
        end
    end

    assign o_in_stall  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_job_pop && o_job_valid;

    // Track fill level
    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    // Store queued jobs
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rdc_back.sv =====
// Back end: divides by the radix, pushes remainders onto the digit stack,
// then pops and emits ASCII digits. Depends on rdc_pkg and rdc_ram.
`default_nettype none

module rdc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_valid,
    input  wire rdc_pkg::t_job               i_job,
    output logic                             o_job_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [rdc_pkg::CHAR_BITS-1:0]    o_digit_char,
    output logic                             o_last_digit,
    output logic                             o_bad_base
);

    import rdc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_BITS-1:0]   r_quot, n_quot;
    logic [REM_BITS-1:0]   r_rem, n_rem;
    logic [BASE_BITS-1:0]  r_base, n_base;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [SP_BITS-1:0]    r_sp, n_sp;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;
    logic                  r_bad, n_bad;

    logic [DIV_BITS-1:0]   w_quot;
    logic [REM_BITS-1:0]   w_rem;
    logic [SP_BITS-1:0]    w_sp_dec;
    logic                  w_out_free;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [DIGIT_BITS-1:0] w_rd_data;

    // Digit stack
    rdc_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (DIGIT_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_sp[ADDR_BITS-1:0]),
        .i_wr_data (w_rem[DIGIT_BITS-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_sp_dec[ADDR_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Retire DIV_STEPS quotient bits of restoring division
    always_comb begin
        logic [REM_BITS-1:0] shifted;
        w_quot  = r_quot;
        w_rem   = r_rem;
        shifted = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            shifted = {w_rem[REM_BITS-2:0], w_quot[DIV_BITS-1]};
            w_quot  = {w_quot[DIV_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, r_base}) begin
                w_rem     = shifted - {1'b0, r_base};
                w_quot[0] = 1'b1;
            end else begin
                w_rem = shifted;
            end
        end
    end

    assign w_sp_dec   = r_sp - 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequence jobs: divide and push, then pop and emit
    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_sp        = r_sp;
        n_out_valid = r_out_valid && i_out_stall;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;
        o_job_pop   = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        K_CONV: begin
                            o_job_pop = 1'b1;
                            n_quot    = DIV_BITS'(i_job.value);
                            n_base    = i_job.base;
                            n_rem     = '0;
                            n_cnt     = '0;
                            n_sp      = '0;
                            n_state   = S_DIV;
                        end
                        K_ZERO, K_BAD: begin
                            // Single-word answer straight to the output
                            if (w_out_free) begin
                                o_job_pop   = 1'b1;
                                n_out_valid = 1'b1;
                                n_char      = (i_job.kind == K_BAD) ? '0 : CHAR_ZERO;
                                n_last      = 1'b1;
                                n_bad       = (i_job.kind == K_BAD);
                            end
                        end
                        default: begin
                            o_job_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_quot = w_quot;
                n_rem  = w_rem;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_CYCLES - 1)) begin
                    // Division done: push remainder, go again on a nonzero quotient until the stack is full
                    w_wr_en = 1'b1;
                    n_sp    = r_sp + 1'b1;
                    n_cnt   = '0;
                    n_rem   = '0;
                    if (w_quot == '0 || r_sp == SP_BITS'(DIGIT_DEPTH - 1)) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_sp    = w_sp_dec;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_to_ascii(w_rd_data);
                    n_last      = (r_sp == '0);
                    n_bad       = 1'b0;
                    if (r_sp == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_sp    = w_sp_dec;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output word
    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;
    assign o_bad_base   = r_bad;

endmodule

`default_nettype wire

// ===== hdl/rdc_checker.sv =====
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter_assert.svh.
`default_nettype none

`include "radix_digit_converter_assert.svh"

module rdc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [rdc_pkg::CHAR_BITS-1:0] o_digit_char,
    input wire logic                          o_last_digit,
    input wire logic                          o_bad_base
);

    // Stalled output word holds
    `RDC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digit_char) && $stable(o_last_digit) && $stable(o_bad_base), "stalled output word changed")

    // Bad radix is a single zero word
    `RDC_ASSERT(a_bad_word, i_clk, i_rst_n, o_out_valid && o_bad_base |-> o_last_digit && (o_digit_char == 8'h00), "bad radix word malformed")

    // Normal words carry a digit character
    `RDC_ASSERT(a_digit_char, i_clk, i_rst_n, o_out_valid && !o_bad_base |-> (o_digit_char >= 8'h30 && o_digit_char <= 8'h39) || (o_digit_char >= 8'h41 && o_digit_char <= 8'h5A), "output is not a digit character")

    // Reset empties both sides
    `RDC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "block not idle after reset")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for radix_digit_converter: a clocked driver and monitor
// with an in-bench digit predictor, directed edge numbers, then random numbers.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`default_nettype none

module testbench;
    import rdc_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [BASE_BITS-1:0]  base;
    } t_number;

    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
        logic                 bad;
    } t_char_word;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [VALUE_BITS-1:0] in_value  = '0;
    logic [BASE_BITS-1:0]  in_base   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [CHAR_BITS-1:0]  digit_char;
    logic                  last_digit;
    logic                  bad_base;

    // Numbers waiting to be offered, and characters still owed by the block
    t_number    numbers_to_send[$];
    t_char_word expected_chars[$];

    // Idling control and the long output hold, set by the stimulus process
    logic idle_on      = 1'b1;
    logic hold_trigger = 1'b0;
    logic hold_taken   = 1'b0;

    int send_gap      = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    int fail_count    = 0;
    int numbers_sent  = 0;
    int bad_numbers   = 0;
    int zero_numbers  = 0;
    int chars_checked = 0;

    radix_digit_converter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_value      (in_value),
        .i_base       (in_base),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_digit_char (digit_char),
        .o_last_digit (last_digit),
        .o_bad_base   (bad_base)
    );

    // Clock and a single reset pulse
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Map one digit value to its ASCII character
    function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
        if (d >= DIGIT_BITS'(DEC_RADIX)) begin
            return CHAR_A + CHAR_BITS'(d - DIGIT_BITS'(DEC_RADIX));
        end
        return CHAR_ZERO + CHAR_BITS'(d);
    endfunction

    // Work out the characters one number turns into and queue them
    task automatic predict_digits(input logic [VALUE_BITS-1:0] value,
                                  input logic [BASE_BITS-1:0] base);
        logic [DIGIT_BITS-1:0] digits[$];
        logic [VALUE_BITS-1:0] rest;
        t_char_word            w;
        rest = value;
        if (base < BASE_MIN || base > BASE_MAX) begin
            bad_numbers++;
            w = '{ch: '0, last: 1'b1, bad: 1'b1};
            expected_chars.push_back(w);
        end else if (value == '0) begin
            zero_numbers++;
            w = '{ch: CHAR_ZERO, last: 1'b1, bad: 1'b0};
            expected_chars.push_back(w);
        end else begin
            // Least significant digit first; stop when the stack would be full
            while (rest != '0 && digits.size() < DIGIT_DEPTH) begin
                digits.push_back(DIGIT_BITS'(rest % VALUE_BITS'(base)));
                rest = rest / VALUE_BITS'(base);
            end
            while (digits.size() > 0) begin
                w.ch   = digit_ascii(digits.pop_back());
                w.last = (digits.size() == 0);
                w.bad  = 1'b0;
                expected_chars.push_back(w);
            end
        end
    endtask

    // Driver: offer queued numbers, holding each until it is taken
    always @(posedge i_clk) begin : send_numbers
        t_number nxt;
        int      gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (in_valid && !in_stall) begin
            predict_digits(in_value, in_base);
            numbers_sent++;
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap == 0 && numbers_to_send.size() > 0) begin
                nxt = numbers_to_send.pop_front();
                in_value <= nxt.value;
                in_base  <= nxt.base;
            end else begin
                in_valid <= 1'b0;
                send_gap <= gap;
            end
        end else if (!in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (numbers_to_send.size() > 0) begin
                nxt = numbers_to_send.pop_front();
                in_value <= nxt.value;
                in_base  <= nxt.base;
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: check each taken character, then draw the next output stall
    always @(posedge i_clk) begin : receive_chars
        t_char_word want;
        int         gap;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected word: char %h last %b bad %b",
                                 digit_char, last_digit, bad_base);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (digit_char !== want.ch || last_digit !== want.last ||
                        bad_base !== want.bad) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch: expected char %h last %b bad %b, got %h %b %b",
                                     want.ch, want.last, want.bad,
                                     digit_char, last_digit, bad_base);
                        end
                    end
                end
            end

            if (hold_trigger && !hold_taken) begin
                // Long hold so the block backs up and stalls its input
                hold_taken <= 1'b1;
                out_stall  <= 1'b1;
                stall_left <= HOLD_CYCLES;
            end else if (out_stall) begin
                if (stall_left <= 1) begin
                    out_stall <= 1'b0;
                end
                stall_left <= stall_left - 1;
            end else if (out_valid) begin
                gap = idle_on ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    out_stall  <= 1'b1;
                    stall_left <= gap;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_number(input logic [VALUE_BITS-1:0] value,
                                input logic [BASE_BITS-1:0] base);
        t_number n;
        n.value = value;
        n.base  = base;
        numbers_to_send.push_back(n);
    endtask

    // Queue random numbers: mostly legal radixes, with a few out of range
    task automatic queue_random(input int count);
        logic [VALUE_BITS-1:0] value;
        logic [BASE_BITS-1:0]  base;
        int                    sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: value = VALUE_BITS'($urandom());
                4, 5:       value = VALUE_BITS'($urandom_range(0, 100));
                6:          value = (VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1))
                                    - VALUE_BITS'($urandom_range(0, 1));
                7:          value = $urandom_range(0, 1) ? VALUE_MAX : '0;
                default:    value = VALUE_BITS'($urandom() >> $urandom_range(1, 31));
            endcase
            sel = $urandom_range(0, 11);
            case (sel)
                0:       base = BASE_BITS'(BASE_MIN);
                1:       base = BASE_BITS'(BASE_MAX);
                2:       base = BASE_BITS'(DEC_RADIX);
                11:      base = $urandom_range(0, 1) ? BASE_BITS'($urandom_range(0, 1))
                                                     : BASE_BITS'($urandom_range(37, 63));
                default: base = BASE_BITS'($urandom_range(BASE_MIN, BASE_MAX));
            endcase
            queue_number(value, base);
        end
    endtask

    task automatic wait_drained;
        while (numbers_to_send.size() != 0 || in_valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Stimulus and end of run
    initial begin
        wait (i_rst_n);
        @(negedge i_clk);

        // Directed: zero, extremes, digit boundaries and out-of-range radixes
        queue_number('0, BASE_BITS'(DEC_RADIX));
        queue_number('0, BASE_BITS'(BASE_MIN));
        queue_number('0, BASE_BITS'(BASE_MAX));
        queue_number(VALUE_MAX, BASE_BITS'(BASE_MIN));
        queue_number(VALUE_MAX, BASE_BITS'(BASE_MAX));
        queue_number(VALUE_MAX, BASE_BITS'(DEC_RADIX));
        queue_number(VALUE_BITS'(1), BASE_BITS'(BASE_MIN));
        queue_number(VALUE_BITS'(35), BASE_BITS'(BASE_MAX));
        queue_number(VALUE_BITS'(36), BASE_BITS'(BASE_MAX));
        queue_number(VALUE_BITS'(9), BASE_BITS'(DEC_RADIX));
        queue_number(VALUE_BITS'(10), BASE_BITS'(16));
        queue_number(VALUE_BITS'(255), BASE_BITS'(16));
        queue_number(VALUE_BITS'(1), BASE_BITS'(BASE_MAX));
        queue_number(VALUE_BITS'(5), BASE_BITS'(0));
        queue_number(VALUE_BITS'(5), BASE_BITS'(1));
        queue_number(VALUE_BITS'(5), BASE_BITS'(37));
        queue_number(VALUE_BITS'(5), BASE_BITS'(63));
        queue_number('0, BASE_BITS'(0));
        queue_number(VALUE_MAX, BASE_BITS'(63));
        queue_number(VALUE_BITS'(32'h5555_5555), BASE_BITS'(BASE_MIN));
        queue_number(VALUE_BITS'(32'h2AAA_AAAA), BASE_BITS'(3));
        queue_number(VALUE_BITS'(1234567890), BASE_BITS'(7));
        wait_drained();

        // Back-to-back traffic with no idling on either side
        idle_on = 1'b0;
        queue_random(80);
        wait_drained();

        // Hold the output for a long stretch while numbers keep coming
        queue_random(30);
        hold_trigger = 1'b1;
        wait_drained();

        // Random idling on both sides
        idle_on = 1'b1;
        queue_random(200);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("converted %0d numbers (%0d zero, %0d bad radix) into %0d checked characters",
                 numbers_sent, zero_numbers, bad_numbers, chars_checked);
        $display("failures: %0d, characters still owed: %0d",
                 fail_count, expected_chars.size());
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
